// ===== design/rds_pkg.sv =====
// Package: shared types and constants for the dead-block stream replacement block.
package rds_pkg;

    localparam int NUM_SETS  = 2048;
    localparam int NUM_WAYS  = 16;
    localparam int SET_W     = 11;
    localparam int WAY_W     = 4;
    localparam int ADDR_W    = 48;
    localparam int LINE_W    = 6 * NUM_WAYS;
    localparam int HIST_W    = 4 * ADDR_W + 2;
    localparam logic [15:0] DECAY_RESET = 16'd4096;
    localparam logic [0:0] OP_VICTIM = 1'b0;

    typedef struct packed {
        logic              opcode;
        logic [SET_W-1:0]  set_index;
        logic [WAY_W-1:0]  way_index;
        logic              hit_flag;
        logic [ADDR_W-1:0] phys_address;
        logic [15:0]       valid_mask;
    } t_in_item;

    typedef struct packed {
        logic [WAY_W-1:0] victim_way;
        logic             stream_flag;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_EXEC, ST_WRITE, ST_DECAY_RD, ST_DECAY_WR
    } t_state;

endpackage

// ===== design/rds_ram.sv =====
// Generic single-port RAM with registered read.
module rds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== design/rrip_deadblock_stream_replacement.sv =====
// Top level: SRRIP replacement with dead-block prediction and stream detection.
// Usage: pulse i_start with i_item while o_busy is low; one result follows on
// o_result with strobe o_done. Victim requests and access updates pass through
// accept, line/history memory read, compute and write back; o_busy is high from
// the memory read through the write-back cycle, and o_done marks the result in
// the cycle after write back, when the next item can already be accepted unless
// a decay sweep starts. One set row (all ways' RRPV, reuse and dead counters)
// lives in one RAM word, the set history in another.
// When an update reaches the decay interval, the block sweeps every other set
// row after the update, reading each row and writing back its decremented dead
// counters while skipping the updated set, busy the whole time.
// After reset, a clearing pass writes every set row and history row, one per
// cycle, with o_busy high. The APB port holds decay_interval at address 0 and
// is taken at any time. The receiver cannot stall: each result is shown for
// exactly one cycle.
module rrip_deadblock_stream_replacement (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  rds_pkg::t_in_item i_item,
    output logic              o_busy,
    output logic              o_done,
    output rds_pkg::t_out_item o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import rds_pkg::*;

    t_state            r_state, n_state;
    t_in_item          r_item, n_item;
    logic [15:0]       r_interval, r_count, n_count;
    logic              r_decay, n_decay;
    logic [SET_W-1:0]  r_ptr, n_ptr;
    logic              r_done, n_done;
    t_out_item         r_res, n_res;
    logic [LINE_W-1:0] r_row, n_row;
    logic [HIST_W-1:0] r_hrow, n_hrow;

    logic              line_we, hist_we;
    logic [SET_W-1:0]  line_addr, hist_addr;
    logic [LINE_W-1:0] line_wd, line_rd;
    logic [HIST_W-1:0] hist_wd, hist_rd;

    rds_ram #(.WIDTH(LINE_W), .DEPTH(NUM_SETS)) u_line (
        .i_clk(i_clk), .i_we(line_we), .i_addr(line_addr),
        .i_wdata(line_wd), .o_rdata(line_rd));
    rds_ram #(.WIDTH(HIST_W), .DEPTH(NUM_SETS)) u_hist (
        .i_clk(i_clk), .i_we(hist_we), .i_addr(hist_addr),
        .i_wdata(hist_wd), .o_rdata(hist_rd));

    assign pready = 1'b1;
    assign prdata = {16'd0, paddr ? 16'd0 : r_interval};
    assign o_busy = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_result = r_res;

    function automatic logic [LINE_W-1:0] reset_row();
        logic [LINE_W-1:0] v;
        v = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            v[6*w +: 6] = 6'b11_01_00;
        end
        return v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_interval <= DECAY_RESET;
            r_count <= '0;
            r_decay <= 1'b0;
            r_ptr <= '0;
            r_done <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_decay <= n_decay;
            r_ptr <= n_ptr;
            r_done <= n_done;
            if (psel && penable && pwrite && !paddr) begin
                r_interval <= pwdata[15:0];
            end
        end
        r_item <= n_item;
        r_res <= n_res;
        r_row <= n_row;
        r_hrow <= n_hrow;
    end

    always_comb begin
        logic [1:0]        rr, ru, dd, top;
        logic [WAY_W-1:0]  vw;
        logic              found, strm;
        logic [1:0]        ptr;
        logic [ADDR_W-1:0] h0, h1, h2, h3;
        logic [1:0]        ins;
        logic [15:0]       cnt;
        rr = '0;
        ru = '0;
        dd = '0;
        top = '0;
        vw = '0;
        found = 1'b0;
        strm = 1'b0;
        ptr = '0;
        h0 = '0;
        h1 = '0;
        h2 = '0;
        h3 = '0;
        ins = '0;
        cnt = '0;
        n_state = r_state;
        n_item = r_item;
        n_count = r_count;
        n_decay = r_decay;
        n_ptr = r_ptr;
        n_done = 1'b0;
        n_res = r_res;
        n_row = r_row;
        n_hrow = r_hrow;
        line_we = 1'b0;
        hist_we = 1'b0;
        line_addr = r_item.set_index;
        hist_addr = r_item.set_index;
        line_wd = r_row;
        hist_wd = r_hrow;
        unique case (r_state)
            ST_CLEAR: begin
                line_we = 1'b1;
                hist_we = 1'b1;
                line_addr = r_ptr;
                hist_addr = r_ptr;
                line_wd = reset_row();
                hist_wd = '0;
                n_ptr = r_ptr + 1'b1;
                if (r_ptr == SET_W'(NUM_SETS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    n_item = i_item;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_row = line_rd;
                n_hrow = hist_rd;
                n_res = '0;
                if (r_item.opcode == OP_VICTIM) begin
                    found = 1'b0;
                    vw = '0;
                    for (int w = 0; w < NUM_WAYS; w++) begin
                        if (!found && !r_item.valid_mask[w]) begin
                            found = 1'b1;
                            vw = WAY_W'(w);
                        end
                    end
                    for (int w = 0; w < NUM_WAYS; w++) begin
                        if (!found && line_rd[6*w +: 2] == 2'd3) begin
                            found = 1'b1;
                            vw = WAY_W'(w);
                        end
                    end
                    if (!found) begin
                        top = '0;
                        for (int w = 0; w < NUM_WAYS; w++) begin
                            rr = line_rd[6*w+4 +: 2];
                            if (rr > top) top = rr;
                        end
                        for (int w = 0; w < NUM_WAYS; w++) begin
                            rr = line_rd[6*w+4 +: 2] + (2'd3 - top);
                            n_row[6*w+4 +: 2] = rr;
                            if (!found && rr == 2'd3) begin
                                found = 1'b1;
                                vw = WAY_W'(w);
                            end
                        end
                    end
                    n_res.victim_way = vw;
                end else begin
                    cnt = r_count + 16'd1;
                    n_decay = (cnt == r_interval);
                    n_count = n_decay ? 16'd0 : cnt;
                    ptr = hist_rd[1:0];
                    h0 = hist_rd[2 +: ADDR_W];
                    h1 = hist_rd[2+ADDR_W +: ADDR_W];
                    h2 = hist_rd[2+2*ADDR_W +: ADDR_W];
                    h3 = r_item.phys_address;
                    n_hrow[2+ptr*ADDR_W +: ADDR_W] = r_item.phys_address;
                    n_hrow[1:0] = ptr + 2'd1;
                    strm = (ptr == 2'd3) && (h1 - h0 == h2 - h1) && (h3 - h2 == h1 - h0);
                    n_res.stream_flag = strm;
                    for (int w = 0; w < NUM_WAYS; w++) begin
                        dd = line_rd[6*w +: 2];
                        ru = line_rd[6*w+2 +: 2];
                        rr = line_rd[6*w+4 +: 2];
                        if (r_item.hit_flag) begin
                            if (r_item.way_index == WAY_W'(w)) begin
                                n_row[6*w+4 +: 2] = 2'd0;
                                if (ru != 2'd3) n_row[6*w+2 +: 2] = ru + 2'd1;
                                if (dd != 2'd0) n_row[6*w +: 2] = dd - 2'd1;
                            end
                        end else if (r_item.way_index == WAY_W'(w)) begin
                            ins = 2'd2;
                            if (ru >= 2'd2) ins = 2'd0;
                            if (dd == 2'd3) ins = 2'd3;
                            if (strm && ru <= 2'd1 && dd >= 2'd2) ins = 2'd3;
                            n_row[6*w +: 6] = {ins, 2'd1, 2'd0};
                        end else if (rr == 2'd3 && dd != 2'd3) begin
                            n_row[6*w +: 2] = dd + 2'd1;
                        end
                    end
                    // decay applies before this access: pre-decrement the row
                    if (n_decay) begin
                        for (int w = 0; w < NUM_WAYS; w++) begin
                            dd = line_rd[6*w +: 2];
                            if (dd != 2'd0) dd = dd - 2'd1;
                            ru = line_rd[6*w+2 +: 2];
                            rr = line_rd[6*w+4 +: 2];
                            if (r_item.hit_flag) begin
                                if (r_item.way_index == WAY_W'(w) && dd != 2'd0) begin
                                    n_row[6*w +: 2] = dd - 2'd1;
                                end else if (r_item.way_index != WAY_W'(w)) begin
                                    n_row[6*w +: 2] = dd;
                                end else begin
                                    n_row[6*w +: 2] = 2'd0;
                                end
                            end else if (r_item.way_index == WAY_W'(w)) begin
                                ins = 2'd2;
                                if (ru >= 2'd2) ins = 2'd0;
                                if (dd == 2'd3) ins = 2'd3;
                                if (strm && ru <= 2'd1 && dd >= 2'd2) ins = 2'd3;
                                n_row[6*w +: 6] = {ins, 2'd1, 2'd0};
                            end else if (rr == 2'd3 && dd != 2'd3) begin
                                n_row[6*w +: 2] = dd + 2'd1;
                            end else begin
                                n_row[6*w +: 2] = dd;
                            end
                        end
                    end
                end
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                line_we = 1'b1;
                hist_we = (r_item.opcode != OP_VICTIM);
                n_done = 1'b1;
                n_ptr = '0;
                if (r_decay) begin
                    n_decay = 1'b0;
                    n_state = ST_DECAY_RD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_DECAY_RD: begin
                line_addr = r_ptr;
                if (r_ptr == r_item.set_index) begin
                    n_ptr = r_ptr + 1'b1;
                    if (r_ptr == SET_W'(NUM_SETS - 1)) n_state = ST_IDLE;
                end else begin
                    n_state = ST_DECAY_WR;
                end
            end
            ST_DECAY_WR: begin
                line_addr = r_ptr;
                line_we = 1'b1;
                line_wd = line_rd;
                for (int w = 0; w < NUM_WAYS; w++) begin
                    if (line_rd[6*w +: 2] != 2'd0) line_wd[6*w +: 2] = line_rd[6*w +: 2] - 2'd1;
                end
                n_ptr = r_ptr + 1'b1;
                n_state = (r_ptr == SET_W'(NUM_SETS - 1)) ? ST_IDLE : ST_DECAY_RD;
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

// ===== design/rds_checker.sv =====
// Checker: port-level properties of the replacement block, bound to the top level.
module rds_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input logic               o_busy,
    input logic               o_done,
    input rds_pkg::t_out_item o_result,
    input logic               pready
);
    import rds_pkg::*;

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe longer than one cycle");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("not busy after accept");
    a_done_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(o_busy)) else $error("result while idle");
    a_ready: assert property (@(posedge i_clk) pready) else $error("pready low");
endmodule

bind rrip_deadblock_stream_replacement rds_checker u_rds_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
    .o_done(o_done), .o_result(o_result), .pready(pready));
